// ===== rtl/ght_pkg.sv =====
package ght_pkg;

  localparam int ID_W      = 8;
  localparam int DATA_W    = 32;
  localparam int GEN_W     = 64;
  localparam int ID_SPACE  = 256;
  localparam int MAX_SLOTS = 64;

  localparam int SLOTS_PER_PAGE_DEF = 32;
  localparam int MAX_PAGES_DEF      = 8;

  localparam logic [GEN_W-1:0] GEN_RESET = 64'd1;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_STALE  = 2'd1,
    STAT_FULL   = 2'd2,
    STAT_BAD_ID = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    logic [1:0]        command;
    logic [DATA_W-1:0] data_in;
    logic [ID_W-1:0]   slot_id;
    logic [GEN_W-1:0]  generation_key;
  } in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ID_W-1:0]   slot_out;
    logic [GEN_W-1:0]  generation_out;
    logic [DATA_W-1:0] data_out;
  } out_t;

  typedef struct packed {
    logic [DATA_W-1:0] payload;
    logic [GEN_W-1:0]  stamp;
  } slot_entry_t;

  // Split every id into {page, slot within page}, counting up without division.
  function automatic logic [ID_SPACE-1:0][15:0] id_map(int spp);
    logic [ID_SPACE-1:0][15:0] map;
    logic [7:0]                page;
    logic [7:0]                bidx;
    page = '0;
    bidx = '0;
    for (int i = 0; i < ID_SPACE; i++) begin
      map[i] = {page, bidx};
      if (int'(bidx) == spp - 1) begin
        bidx = '0;
        page = page + 8'd1;
      end else begin
        bidx = bidx + 8'd1;
      end
    end
    return map;
  endfunction

  // Slots of one page whose id lies inside the id space.
  function automatic logic [MAX_SLOTS-1:0] page_valid_mask(int spp, int cap, int page);
    logic [MAX_SLOTS-1:0] m;
    m = '0;
    for (int b = 0; b < MAX_SLOTS; b++) begin
      if (b < spp && page * spp + b < cap) m[b] = 1'b1;
    end
    return m;
  endfunction

endpackage

// ===== rtl/ght_ram.sv =====
module ght_ram #(
  parameter int DEPTH = ght_pkg::MAX_PAGES_DEF,
  parameter int WIDTH = ght_pkg::SLOTS_PER_PAGE_DEF
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

// ===== rtl/ght_find_first.sv =====
module ght_find_first #(
  parameter int W = ght_pkg::SLOTS_PER_PAGE_DEF
) (
  input  logic [W-1:0]                     vec,
  output logic                             found,
  output logic [(W > 1 ? $clog2(W) : 1)-1:0] index
);

  localparam int IW = W > 1 ? $clog2(W) : 1;

  // Lowest set bit wins: scan from the top so the last hit is the lowest.
  always_comb begin
    found = |vec;
    index = '0;
    for (int i = W - 1; i >= 0; i--) begin
      if (vec[i]) index = IW'(i);
    end
  end

endmodule

// ===== rtl/generational_handle_table.sv =====
// Channel | Direction  | Handshake             | Payload
// --------+------------+-----------------------+------------------------------------------
// in      | to block   | in_valid / in_ready   | in_item : command, data_in, slot_id, key
// out     | from block | out_valid / out_ready | out_item: status, slot, generation, data
//
// Each transaction has an accept cycle and an execute cycle: the accept cycle issues the
// synchronous reads of the occupancy and slot memories, the execute cycle updates and
// writes back. The next request is accepted only after the write back, so no read
// overlaps a write to the same entry. Reset needs no clearing pass: a page is zeroed
// when it is opened. A result waiting in the output register does not block acceptance;
// execute holds only while that register is still occupied.
module generational_handle_table #(
  parameter int SLOTS_PER_PAGE = ght_pkg::SLOTS_PER_PAGE_DEF,
  parameter int MAX_PAGES      = ght_pkg::MAX_PAGES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  ght_pkg::in_t  in_item,
  output logic          out_valid,
  input  logic          out_ready,
  output ght_pkg::out_t out_item
);

  localparam int RAW_CAP    = SLOTS_PER_PAGE * MAX_PAGES;
  localparam int CAPACITY   = RAW_CAP < ght_pkg::ID_SPACE ? RAW_CAP : ght_pkg::ID_SPACE;
  localparam int USED_PAGES = (CAPACITY + SLOTS_PER_PAGE - 1) / SLOTS_PER_PAGE;
  localparam int PG_W       = MAX_PAGES > 1 ? $clog2(MAX_PAGES) : 1;
  localparam int BIT_W      = $clog2(SLOTS_PER_PAGE);
  localparam int CNT_W      = $clog2(MAX_PAGES + 1);
  localparam int SLOT_AW    = $clog2(CAPACITY);
  localparam int PICK_W     = PG_W + BIT_W + 1;
  localparam int ID_W       = ght_pkg::ID_W;
  localparam int GEN_W      = ght_pkg::GEN_W;

  localparam logic [ght_pkg::ID_SPACE-1:0][15:0] ID_MAP = ght_pkg::id_map(SLOTS_PER_PAGE);

  // Control state
  ght_pkg::state_e      state, state_next;
  logic [CNT_W-1:0]     pages_open;
  logic [MAX_PAGES-1:0] page_full;
  logic [GEN_W-1:0]     gen_count;

  // Request held through execute
  ght_pkg::in_t         req;
  logic [PG_W-1:0]      page_sel;
  logic [BIT_W-1:0]     bit_id;
  logic                 open_new;
  logic                 room;
  logic                 id_ok;

  // Constant per-page mask of slots inside the id space
  logic [SLOTS_PER_PAGE-1:0] page_mask [MAX_PAGES];
  logic [MAX_PAGES-1:0]      open_mask;

  for (genvar g = 0; g < MAX_PAGES; g++) begin : g_page
    localparam logic [ght_pkg::MAX_SLOTS-1:0] VMASK =
      ght_pkg::page_valid_mask(SLOTS_PER_PAGE, CAPACITY, g);
    assign page_mask[g] = VMASK[SLOTS_PER_PAGE-1:0];
    assign open_mask[g] = CNT_W'(g) < pages_open;
  end

  // ---------------------------------------------------------------------------
  // Accept side: pick the page to read
  // ---------------------------------------------------------------------------
  logic            accept;
  logic [15:0]     id_entry;
  logic [7:0]      id_page;
  logic            id_ok_now;
  logic            fp_found;
  logic [PG_W-1:0] fp_idx;
  logic            can_open;
  logic            is_alloc_in;
  logic [PG_W-1:0] rd_page;

  assign in_ready    = (state == ght_pkg::S_IDLE);
  assign accept      = in_valid && in_ready;
  assign id_entry    = ID_MAP[in_item.slot_id];
  assign id_page     = id_entry[15:8];
  assign id_ok_now   = ({1'b0, in_item.slot_id} < 9'(CAPACITY)) &&
                       (id_page < 8'(pages_open));
  assign can_open    = pages_open < CNT_W'(USED_PAGES);
  assign is_alloc_in = (in_item.command == ght_pkg::CMD_ALLOC);

  // First open page that still has a free slot
  ght_find_first #(.W(MAX_PAGES)) u_page_find (
    .vec   (open_mask & ~page_full),
    .found (fp_found),
    .index (fp_idx)
  );

  always_comb begin
    if (is_alloc_in) begin
      rd_page = fp_found ? fp_idx : pages_open[PG_W-1:0];
    end else begin
      rd_page = id_page[PG_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Memories
  // ---------------------------------------------------------------------------
  logic                      bm_we;
  logic [SLOTS_PER_PAGE-1:0] bm_wdata;
  logic [SLOTS_PER_PAGE-1:0] bm_rdata;
  logic                      slot_we;
  logic [SLOT_AW-1:0]        slot_waddr;
  ght_pkg::slot_entry_t      slot_wdata;
  logic [$bits(ght_pkg::slot_entry_t)-1:0] slot_rdata;
  ght_pkg::slot_entry_t      slot_rd;

  ght_ram #(.DEPTH(MAX_PAGES), .WIDTH(SLOTS_PER_PAGE)) u_bitmap_ram (
    .clk   (clk),
    .we    (bm_we),
    .waddr (page_sel),
    .wdata (bm_wdata),
    .re    (accept),
    .raddr (rd_page),
    .rdata (bm_rdata)
  );

  ght_ram #(.DEPTH(CAPACITY), .WIDTH($bits(ght_pkg::slot_entry_t))) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .re    (accept),
    .raddr (in_item.slot_id[SLOT_AW-1:0]),
    .rdata (slot_rdata)
  );

  assign slot_rd = slot_rdata;

  // ---------------------------------------------------------------------------
  // Execute side: modify and write back
  // ---------------------------------------------------------------------------
  logic                      exec_go;
  logic [SLOTS_PER_PAGE-1:0] bits_cur;
  logic [SLOTS_PER_PAGE-1:0] cur_mask;
  logic [SLOTS_PER_PAGE-1:0] bit_hot;
  logic [SLOTS_PER_PAGE-1:0] bits_new;
  logic                      ff_found;
  logic [BIT_W-1:0]          ff_idx;
  logic [BIT_W-1:0]          bit_sel;
  logic                      is_alloc;
  logic                      in_use;
  logic                      full_new;
  logic [PICK_W-1:0]         pick;
  logic [GEN_W-1:0]          gen_inc;
  ght_pkg::out_t             rsp;

  // Hold execute while the output register still carries an untaken result
  assign exec_go  = (state == ght_pkg::S_EXEC) && (!out_valid || out_ready);
  assign is_alloc = (req.command == ght_pkg::CMD_ALLOC);
  assign bits_cur = open_new ? '0 : bm_rdata;
  assign cur_mask = page_mask[page_sel];

  ght_find_first #(.W(SLOTS_PER_PAGE)) u_slot_find (
    .vec   (~bits_cur & cur_mask),
    .found (ff_found),
    .index (ff_idx)
  );

  assign bit_sel  = is_alloc ? ff_idx : bit_id;
  assign bit_hot  = {{(SLOTS_PER_PAGE - 1){1'b0}}, 1'b1} << bit_sel;
  assign in_use   = id_ok && bits_cur[bit_sel];
  assign bits_new = is_alloc ? (bits_cur | bit_hot) : (bits_cur & ~bit_hot);
  assign full_new = &(bits_new | ~cur_mask);
  assign pick     = PICK_W'(page_sel) * PICK_W'(SLOTS_PER_PAGE) + PICK_W'(bit_sel);
  assign gen_inc  = gen_count + GEN_W'(1);

  assign bm_we      = exec_go && ((is_alloc && room) ||
                                  (req.command == ght_pkg::CMD_FREE && in_use));
  assign bm_wdata   = bits_new;
  assign slot_we    = exec_go && is_alloc && room;
  assign slot_waddr = pick[SLOT_AW-1:0];
  assign slot_wdata = '{payload: req.data_in, stamp: gen_inc};

  always_comb begin
    rsp = '0;
    unique case (req.command)
      ght_pkg::CMD_ALLOC: begin
        if (room) begin
          rsp.status         = ght_pkg::STAT_OK;
          rsp.slot_out       = pick[ID_W-1:0];
          rsp.generation_out = gen_inc;
        end else begin
          rsp.status = ght_pkg::STAT_FULL;
        end
      end
      ght_pkg::CMD_FREE: begin
        rsp.status = in_use ? ght_pkg::STAT_OK : ght_pkg::STAT_BAD_ID;
      end
      ght_pkg::CMD_QUERY: begin
        if (in_use && slot_rd.stamp == req.generation_key) begin
          rsp.status   = ght_pkg::STAT_OK;
          rsp.data_out = slot_rd.payload;
        end else begin
          rsp.status = ght_pkg::STAT_STALE;
        end
      end
      ght_pkg::CMD_CLEAR: begin
        rsp.status = ght_pkg::STAT_OK;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // State machine
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      ght_pkg::S_IDLE: if (accept) state_next = ght_pkg::S_EXEC;
      ght_pkg::S_EXEC: if (exec_go) state_next = ght_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ght_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the request and the page decision at accept
  always_ff @(posedge clk) begin
    if (accept) begin
      req      <= in_item;
      page_sel <= rd_page;
      bit_id   <= id_entry[BIT_W-1:0];
      open_new <= is_alloc_in && !fp_found;
      room     <= fp_found || can_open;
      id_ok    <= id_ok_now;
    end
  end

  // Table bookkeeping; clear closes every page and keeps the generation
  always_ff @(posedge clk) begin
    if (rst) begin
      pages_open <= '0;
      page_full  <= '0;
      gen_count  <= ght_pkg::GEN_RESET;
    end else if (exec_go) begin
      unique case (req.command)
        ght_pkg::CMD_ALLOC: begin
          if (room) begin
            gen_count           <= gen_inc;
            page_full[page_sel] <= full_new;
            if (open_new) pages_open <= pages_open + CNT_W'(1);
          end
        end
        ght_pkg::CMD_FREE: begin
          if (in_use) page_full[page_sel] <= 1'b0;
        end
        ght_pkg::CMD_QUERY: begin
        end
        ght_pkg::CMD_CLEAR: begin
          pages_open <= '0;
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) out_item <= rsp;
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_open_bound: assert property (@(posedge clk) disable iff (rst)
    pages_open <= CNT_W'(USED_PAGES))
    else $error("open page count beyond usable pages");

  a_alloc_free_slot: assert property (@(posedge clk) disable iff (rst)
    state == ght_pkg::S_EXEC && is_alloc && room |-> ff_found && !bits_cur[bit_sel])
    else $error("allocate picked an occupied slot");

  a_alloc_in_space: assert property (@(posedge clk) disable iff (rst)
    slot_we |-> pick < PICK_W'(CAPACITY))
    else $error("allocate picked an id outside the id space");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status != ght_pkg::STAT_OK |->
      out_item.slot_out == '0 && out_item.generation_out == '0 && out_item.data_out == '0)
    else $error("error result carries nonzero fields");

  a_gen_step: assert property (@(posedge clk) disable iff (rst)
    slot_we |=> gen_count == $past(gen_count) + GEN_W'(1))
    else $error("generation did not advance on allocate");

endmodule
